/* rtl/aps_pkg.sv */
package aps_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PRI_W       = 16;
    localparam int KIND_W      = 2;

    localparam logic [PRI_W-1:0] PRI_MAX = {PRI_W{1'b1}};

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SCHED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FORK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_KILL  = 2'd3;

    // entry status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]       status;
        logic [PRI_W-1:0] pri;
        logic [IDX_W-1:0] parent;
    } entry_t;

    localparam entry_t ENTRY_ROOT = '{status: ST_RUN, pri: PRI_W'(1), parent: '0};

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             age;
        logic             shift;
        logic [IDX_W-1:0] rem_idx;
        logic [IDX_W-1:0] new_par;
        logic [CNT_W-1:0] new_live;
        logic             set_ready;
        logic [IDX_W-1:0] ready_idx;
        logic             set_run;
        logic [IDX_W-1:0] run_idx;
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic [PRI_W-1:0] load_pri;
        logic [IDX_W-1:0] load_par;
    } cell_cmd_t;

endpackage

/* rtl/aging_priority_process_scheduler_unit.sv */
// Aging priority scheduler over a table of process entries.
// Command channel: an item (kind, target, exit_zero) is taken at a rising
// edge with start high and busy low; busy then stays high until the result
// is out. Result channel: running, switched, new_index, count and error are
// valid for the single cycle in which done is high; the receiver cannot
// stall, so nothing is held back. running and count also hold their values
// between items.
// Path from the accepting edge to the result: fork and the cases that remove
// nothing finish in the decode state, exit and kill go on to a removal state,
// and schedule ages in the decode state, then loads the best entry, scans
// every live entry and commits in a switch state. The priority scan reads one
// entry per cycle through a single compare unit. Items are handled one at a
// time; start may be raised again in the cycle done is high.
// Reset puts entry 0 running with priority one, all other entries empty,
// count at one, and clears busy and done.
module aging_priority_process_scheduler_unit
    import aps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] kind,
    input  logic [IDX_W-1:0]  target,
    input  logic              exit_zero,
    output logic              done,
    output logic [IDX_W-1:0]  running,
    output logic              switched,
    output logic [IDX_W-1:0]  new_index,
    output logic [CNT_W-1:0]  count,
    output logic              error
);

    // each cell holds one table entry; removal makes every cell at or above the
    // removed index take its upper neighbour's entry, with the parent relink done in-cell
    entry_t [MAX_ENTRIES-1:0] entries;
    entry_t [MAX_ENTRIES:0]   chain;
    cell_cmd_t                cmd;

    assign chain[MAX_ENTRIES] = '0;   // slot above the top cell reads empty

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            aps_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .idx   (IDX_W'(g)),
                .up    (chain[g+1]),
                .cmd   (cmd),
                .entry (entries[g])
            );
            assign chain[g] = entries[g];
        end
    endgenerate

    // sequencer: decode, aging, scan, commit
    aps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .target    (target),
        .exit_zero (exit_zero),
        .entries   (entries),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .running   (running),
        .switched  (switched),
        .new_index (new_index),
        .count     (count),
        .error     (error)
    );

endmodule

/* rtl/aps_cell.sv */
module aps_cell
    import aps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  entry_t           up,
    input  cell_cmd_t        cmd,
    output entry_t           entry
);

    entry_t           entry_reg;
    entry_t           entry_next;
    entry_t           src;
    logic [IDX_W-1:0] q;

    always_comb
    begin
        entry_next = entry_reg;
        src        = entry_reg;
        q          = entry_reg.parent;

        if (cmd.age)
        begin
            if (entry_reg.status == ST_READY)
            begin
                if (entry_reg.pri != PRI_MAX)
                begin
                    entry_next.pri = entry_reg.pri + PRI_W'(1);
                end
            end
            else if (entry_reg.status == ST_RUN)
            begin
                entry_next.pri = '0;
            end
        end

        // removal: take the upper neighbour's entry, then relink the parent
        if (cmd.shift)
        begin
            if (idx >= cmd.rem_idx)
            begin
                src = up;
            end
            q = src.parent;
            if (CNT_W'(idx) < cmd.new_live)
            begin
                if (q == cmd.rem_idx)
                begin
                    q = cmd.new_par;
                end
                else if (q > cmd.rem_idx)
                begin
                    q = q - IDX_W'(1);
                end
                if (CNT_W'(q) >= cmd.new_live)
                begin
                    q = '0;
                end
            end
            entry_next        = src;
            entry_next.parent = q;
        end

        if (cmd.set_ready && (idx == cmd.ready_idx))
        begin
            entry_next.status = ST_READY;
        end
        if (cmd.set_run && (idx == cmd.run_idx))
        begin
            entry_next.status = ST_RUN;
        end

        if (cmd.load && (idx == cmd.load_idx))
        begin
            entry_next.status = ST_READY;
            entry_next.pri    = cmd.load_pri;
            entry_next.parent = cmd.load_par;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= (idx == '0) ? ENTRY_ROOT : '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

/* rtl/aps_ctrl.sv */
module aps_ctrl
    import aps_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [KIND_W-1:0]             kind,
    input  logic [IDX_W-1:0]              target,
    input  logic                          exit_zero,
    input  entry_t [MAX_ENTRIES-1:0]      entries,
    output cell_cmd_t                     cmd,
    output logic                          busy,
    output logic                          done,
    output logic [IDX_W-1:0]              running,
    output logic                          switched,
    output logic [IDX_W-1:0]              new_index,
    output logic [CNT_W-1:0]              count,
    output logic                          error
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_BEST   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_SWITCH = 6'b010000,
        S_REMOVE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [IDX_W-1:0]  target_reg, target_next;
    logic              exz_reg, exz_next;
    logic [IDX_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PRI_W-1:0]  best_reg, best_next;
    logic [IDX_W-1:0]  win_reg, win_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  np_reg, np_next;
    logic              sw_reg, sw_next;
    logic [IDX_W-1:0]  new_reg, new_next;
    logic              err_reg, err_next;
    logic              done_reg, done_next;

    logic [IDX_W-1:0]  rem_sel;
    logic [IDX_W-1:0]  par_sel;
    logic [IDX_W-1:0]  np_calc;
    logic [CNT_W-1:0]  live_m1;

    assign live_m1 = live_reg - CNT_W'(1);
    assign rem_sel = (kind_reg == KIND_EXIT) ? run_reg : target_reg;
    assign par_sel = entries[rem_sel].parent;

    // parent's index once the removed entry is gone
    always_comb
    begin
        if (par_sel < rem_sel)
        begin
            np_calc = par_sel;
        end
        else if (par_sel == rem_sel)
        begin
            np_calc = rem_sel;
        end
        else
        begin
            np_calc = par_sel - IDX_W'(1);
        end
        if (CNT_W'(np_calc) >= live_m1)
        begin
            np_calc = '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        target_next = target_reg;
        exz_next    = exz_reg;
        run_next    = run_reg;
        live_next   = live_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        win_next    = win_reg;
        rem_next    = rem_reg;
        np_next     = np_reg;
        sw_next     = sw_reg;
        new_next    = new_reg;
        err_next    = err_reg;
        done_next   = 1'b0;
        cmd         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = kind;
                    target_next = target;
                    exz_next    = exit_zero;
                    sw_next     = 1'b0;
                    new_next    = '0;
                    err_next    = 1'b0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (kind_reg)
                    KIND_SCHED:
                    begin
                        cmd.age    = 1'b1;
                        state_next = S_BEST;
                    end
                    KIND_FORK:
                    begin
                        if (live_reg >= CNT_W'(MAX_ENTRIES))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cmd.load     = 1'b1;
                            cmd.load_idx = live_reg[IDX_W-1:0];
                            cmd.load_pri = entries[run_reg].pri;
                            cmd.load_par = run_reg;
                            new_next     = live_reg[IDX_W-1:0];
                            live_next    = live_reg + CNT_W'(1);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    KIND_EXIT:
                    begin
                        if (exz_reg && (live_reg >= CNT_W'(2)))
                        begin
                            rem_next   = rem_sel;
                            np_next    = np_calc;
                            state_next = S_REMOVE;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    KIND_KILL:
                    begin
                        if ((CNT_W'(target_reg) >= live_reg) || (live_reg < CNT_W'(2)))
                        begin
                            err_next   = 1'b1;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rem_next   = rem_sel;
                            np_next    = np_calc;
                            state_next = S_REMOVE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_BEST:
            begin
                best_next  = entries[run_reg].pri;
                win_next   = run_reg;
                idx_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (entries[idx_reg].pri >= best_reg)
                begin
                    best_next = entries[idx_reg].pri;
                    win_next  = idx_reg;
                end
                if (CNT_W'(idx_reg) == live_m1)
                begin
                    state_next = S_SWITCH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_SWITCH:
            begin
                if (win_reg != run_reg)
                begin
                    cmd.set_ready = 1'b1;
                    cmd.ready_idx = run_reg;
                    cmd.set_run   = 1'b1;
                    cmd.run_idx   = win_reg;
                    run_next      = win_reg;
                    sw_next       = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_REMOVE:
            begin
                cmd.shift    = 1'b1;
                cmd.rem_idx  = rem_reg;
                cmd.new_par  = np_reg;
                cmd.new_live = live_m1;
                live_next    = live_m1;
                if (rem_reg == run_reg)
                begin
                    cmd.set_run = 1'b1;
                    cmd.run_idx = np_reg;
                    run_next    = np_reg;
                    sw_next     = 1'b1;
                end
                else if (rem_reg < run_reg)
                begin
                    run_next = run_reg - IDX_W'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= '0;
            live_reg  <= CNT_W'(1);
            done_reg  <= 1'b0;
            sw_reg    <= 1'b0;
            new_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            live_reg  <= live_next;
            done_reg  <= done_next;
            sw_reg    <= sw_next;
            new_reg   <= new_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        target_reg <= target_next;
        exz_reg    <= exz_next;
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        win_reg    <= win_next;
        rem_reg    <= rem_next;
        np_reg     <= np_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign running   = run_reg;
    assign switched  = sw_reg;
    assign new_index = new_reg;
    assign count     = live_reg;
    assign error     = err_reg;

endmodule

/* rtl/aps_checker.sv */
module aps_checker
    import aps_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [KIND_W-1:0] kind,
    input logic [IDX_W-1:0]  target,
    input logic              exit_zero,
    input logic              done,
    input logic [IDX_W-1:0]  running,
    input logic              switched,
    input logic [IDX_W-1:0]  new_index,
    input logic [CNT_W-1:0]  count,
    input logic              error
);

    // a transfer in always leads to a busy period
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // busy ends exactly when the result is shown
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_fell: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("result without a finished command");

    // state visible on the ports moves only with a result
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(count) && $stable(running)))
        else $error("count or running changed outside a result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count != '0) && (count <= CNT_W'(MAX_ENTRIES))
        && (CNT_W'(running) < count))
        else $error("count or running out of range");

endmodule

bind aging_priority_process_scheduler_unit aps_checker u_aps_checker (.*);
